// ===== hdl/armc_pkg.sv =====
// Package for the auto-repeat menu cursor: constants, codes and shared types.
package armc_pkg;

  // Defaults for the top-level parameters
  localparam int ENTRIES_DEFAULT     = 8;
  localparam int MAX_CHOICES_DEFAULT = 16;

  // Number of entries the kind and count registers describe
  localparam int REG_SLOTS = 8;

  // Field and register widths
  localparam int CURSOR_W  = 3;
  localparam int CHOICE_W  = 4;
  localparam int COUNT_W   = 4;
  localparam int KINDS_W   = 16;
  localparam int CHOICES_W = 32;
  localparam int THR_W     = 8;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;
  localparam int DIRS      = 4;

  // Auto-repeat constants
  localparam logic [THR_W-1:0]   REPEAT_FALLBACK = THR_W'(4);
  localparam logic [THR_W-1:0]   THRESHOLD_RESET = THR_W'(30);
  localparam logic [COUNT_W-1:0] COUNT_RESET     = COUNT_W'(1);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_KINDS      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CHOICE_COUNTS    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_REPEAT_THRESHOLD = 2'd3;

  // Direction lane order
  localparam int DIR_UP    = 0;
  localparam int DIR_DOWN  = 1;
  localparam int DIR_LEFT  = 2;
  localparam int DIR_RIGHT = 3;

  // Entry kinds, two bits per entry
  typedef enum logic [1:0] {
    KIND_ABSENT = 2'd0,
    KIND_BUTTON = 2'd1,
    KIND_INPUT  = 2'd2,
    KIND_CHOICE = 2'd3
  } kind_e;

  // Qualified moves from the key lanes to the merge stage
  typedef struct packed {
    logic up;
    logic down;
    logic left;
    logic right;
  } moves_t;

endpackage

// ===== hdl/armc_if.sv =====
// Handshake channel interfaces: key word in, cursor word out, register writes.
interface armc_in_if;
  logic valid;
  logic ready;
  logic key_up;
  logic key_down;
  logic key_left;
  logic key_right;
  logic key_fire;

  modport source (output valid, key_up, key_down, key_left, key_right, key_fire,
                  input ready);
  modport sink   (input valid, key_up, key_down, key_left, key_right, key_fire,
                  output ready);
endinterface

interface armc_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] cursor;
  logic [3:0] choice_index;
  logic       activate;

  modport source (output valid, cursor, choice_index, activate, input ready);
  modport sink   (input valid, cursor, choice_index, activate, output ready);
endinterface

interface armc_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  idx;
  logic [31:0] wdata;

  modport source (output valid, idx, wdata, input ready);
  modport sink   (input valid, idx, wdata, output ready);
endinterface

// ===== hdl/armc_key_lane.sv =====
// One direction key lane: hold counter, press edge and auto-repeat qualify.
module armc_key_lane (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      level_i,
  input  logic [armc_pkg::THR_W-1:0] thr_i,
  output logic                      move_o
);
  import armc_pkg::*;

  logic [THR_W-1:0] hold_q, hold_d;
  logic             prev_q;
  logic [THR_W:0]   inc;

  // Count while held, fall back once past the threshold
  always_comb begin
    inc = level_i ? ({1'b0, hold_q} + (THR_W+1)'(1)) : '0;
    if (inc > {1'b0, thr_i}) begin
      hold_d = thr_i - REPEAT_FALLBACK;
    end else begin
      hold_d = inc[THR_W-1:0];
    end
  end

  assign move_o = (level_i & ~prev_q) | (hold_d >= thr_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q <= '0;
      prev_q <= 1'b0;
    end else if (en_i) begin
      hold_q <= hold_d;
      prev_q <= level_i;
    end
  end

endmodule

// ===== hdl/armc_nav.sv =====
// Merge stage: wrapping cursor, per-entry choice positions and activate.
module armc_nav #(
  parameter int ENTRIES     = armc_pkg::ENTRIES_DEFAULT,
  parameter int MAX_CHOICES = armc_pkg::MAX_CHOICES_DEFAULT
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  armc_pkg::moves_t               moves_i,
  input  logic                           fire_i,
  input  logic [armc_pkg::COUNT_W-1:0]   entry_count_i,
  input  logic [armc_pkg::KINDS_W-1:0]   entry_kinds_i,
  input  logic [armc_pkg::CHOICES_W-1:0] choice_counts_i,
  output logic [armc_pkg::CURSOR_W-1:0]  cursor_o,
  output logic [armc_pkg::CHOICE_W-1:0]  choice_o,
  output logic                           activate_o
);
  import armc_pkg::*;

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CAP   = (ENTRIES < REG_SLOTS) ? ENTRIES : REG_SLOTS;

  logic [CURSOR_W-1:0] cursor_q, cursor_d;
  logic [CHOICE_W-1:0] choice_q [ENTRIES];

  logic [COUNT_W-1:0]  count;
  logic [4:0]          cur_ext;
  logic                in_range;
  logic [IDX_W-1:0]    idx;
  kind_e               kind;
  logic [4:0]          nch_raw;
  logic [4:0]          nch;
  logic [CHOICE_W-1:0] pos;
  logic [CHOICE_W-1:0] pos_d;
  logic                choice_wr;

  // Cursor: saturate the entry count, then wrap (up wins over down)
  always_comb begin
    count = (entry_count_i > COUNT_W'(CAP)) ? COUNT_W'(CAP) : entry_count_i;
    cursor_d = cursor_q;
    if (count != '0) begin
      if (moves_i.up) begin
        cursor_d = (cursor_q != '0) ? cursor_q - CURSOR_W'(1)
                                    : CURSOR_W'(count - COUNT_W'(1));
      end else if (moves_i.down) begin
        cursor_d = (({1'b0, cursor_q} + COUNT_W'(1)) < count) ?
                   cursor_q + CURSOR_W'(1) : '0;
      end
    end
  end

  // Look up the selected entry
  always_comb begin
    cur_ext  = {2'b00, cursor_d};
    in_range = (cur_ext < 5'(ENTRIES));
    idx      = cur_ext[IDX_W-1:0];
    if (in_range) begin
      kind    = kind_e'(entry_kinds_i[2*cursor_d +: 2]);
      nch_raw = {1'b0, choice_counts_i[4*cursor_d +: 4]};
      pos     = choice_q[idx];
    end else begin
      kind    = KIND_ABSENT;
      nch_raw = '0;
      pos     = '0;
    end
    nch = (nch_raw > 5'(MAX_CHOICES)) ? 5'(MAX_CHOICES) : nch_raw;
  end

  // Choice wrap on choice entries (left wins over right)
  always_comb begin
    pos_d = pos;
    if (nch != '0) begin
      if (moves_i.left) begin
        pos_d = (pos != '0) ? pos - CHOICE_W'(1) : CHOICE_W'(nch - 5'd1);
      end else if (moves_i.right) begin
        pos_d = (({1'b0, pos} + 5'd1) < nch) ? pos + CHOICE_W'(1) : '0;
      end
    end
    choice_wr = (kind == KIND_CHOICE);
  end

  // Result word
  always_comb begin
    cursor_o   = cursor_d;
    choice_o   = choice_wr ? pos_d : pos;
    activate_o = (kind == KIND_BUTTON) & fire_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
      for (int e = 0; e < ENTRIES; e++) begin
        choice_q[e] <= '0;
      end
    end else if (en_i) begin
      cursor_q <= cursor_d;
      if (choice_wr && in_range) begin
        choice_q[idx] <= pos_d;
      end
    end
  end

endmodule

// ===== hdl/auto_repeat_menu_cursor.sv =====
// Top level of the auto-repeat menu cursor: config registers, key lanes, output register.
//
//  channel  dir  handshake      word
//  -------  ---  -------------  ----------------------------------------------
//  in_i     in   valid/ready    key_up, key_down, key_left, key_right, key_fire
//  out_o    out  valid/ready    cursor, choice_index, activate
//  cfg_i    in   valid/ready    idx (register index), wdata
//
// One word per cycle unless out_o stalls: the four key lanes and the cursor merge
// resolve in the accept cycle, the result is captured in the output register at
// the accepting edge and offered on out_o from the next cycle on.
// The input is ready whenever the output register is empty or being drained.
// Reset clears lane counters, cursor and choice positions and loads config defaults.
// cfg_i is always ready.
module auto_repeat_menu_cursor #(
  parameter int ENTRIES     = armc_pkg::ENTRIES_DEFAULT,
  parameter int MAX_CHOICES = armc_pkg::MAX_CHOICES_DEFAULT
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  armc_in_if.sink    in_i,
  armc_out_if.source out_o,
  armc_cfg_if.sink   cfg_i
);
  import armc_pkg::*;

  logic [COUNT_W-1:0]   entry_count_q;
  logic [KINDS_W-1:0]   entry_kinds_q;
  logic [CHOICES_W-1:0] choice_counts_q;
  logic [THR_W-1:0]     threshold_q;
  logic [THR_W-1:0]     thr;

  logic                 accept;
  logic [DIRS-1:0]      keys;
  logic [DIRS-1:0]      move_vec;
  moves_t               moves;

  logic [CURSOR_W-1:0]  res_cursor;
  logic [CHOICE_W-1:0]  res_choice;
  logic                 res_act;

  logic                 out_valid_q;
  logic [CURSOR_W-1:0]  cursor_q;
  logic [CHOICE_W-1:0]  choice_q;
  logic                 act_q;

  // Config register writes
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_count_q   <= COUNT_RESET;
      entry_kinds_q   <= '0;
      choice_counts_q <= '0;
      threshold_q     <= THRESHOLD_RESET;
    end else if (cfg_i.valid) begin
      case (cfg_i.idx)
        REG_ENTRY_COUNT:      entry_count_q   <= cfg_i.wdata[COUNT_W-1:0];
        REG_ENTRY_KINDS:      entry_kinds_q   <= cfg_i.wdata[KINDS_W-1:0];
        REG_CHOICE_COUNTS:    choice_counts_q <= cfg_i.wdata[CHOICES_W-1:0];
        REG_REPEAT_THRESHOLD: threshold_q     <= cfg_i.wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Thresholds below the fallback step act as the fallback step
  assign thr = (threshold_q < REPEAT_FALLBACK) ? REPEAT_FALLBACK : threshold_q;

  // Input handshake
  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign accept     = in_i.valid & in_i.ready;

  always_comb begin
    keys            = '0;
    keys[DIR_UP]    = in_i.key_up;
    keys[DIR_DOWN]  = in_i.key_down;
    keys[DIR_LEFT]  = in_i.key_left;
    keys[DIR_RIGHT] = in_i.key_right;
  end

  // Key lanes, one per direction
  for (genvar g = 0; g < DIRS; g++) begin : g_lane
    armc_key_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (accept),
      .level_i (keys[g]),
      .thr_i   (thr),
      .move_o  (move_vec[g])
    );
  end

  always_comb begin
    moves.up    = move_vec[DIR_UP];
    moves.down  = move_vec[DIR_DOWN];
    moves.left  = move_vec[DIR_LEFT];
    moves.right = move_vec[DIR_RIGHT];
  end

  // Merge stage
  armc_nav #(
    .ENTRIES     (ENTRIES),
    .MAX_CHOICES (MAX_CHOICES)
  ) u_nav (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .en_i            (accept),
    .moves_i         (moves),
    .fire_i          (in_i.key_fire),
    .entry_count_i   (entry_count_q),
    .entry_kinds_i   (entry_kinds_q),
    .choice_counts_i (choice_counts_q),
    .cursor_o        (res_cursor),
    .choice_o        (res_choice),
    .activate_o      (res_act)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cursor_q <= res_cursor;
      choice_q <= res_choice;
      act_q    <= res_act;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.cursor       = cursor_q;
  assign out_o.choice_index = choice_q;
  assign out_o.activate     = act_q;

endmodule
